[hw/rtl/dqsa_pkg.sv]
// shared types and constants for the two-queue shared array
package dqsa_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 2;
    localparam int QSW   = 7;
    localparam int DW    = 32;
    localparam int CW    = (PW > QSW + 1) ? PW : QSW + 1;

    typedef logic signed [PW-1:0] t_ptr;

    localparam t_ptr PTR_NONE  = '1;
    localparam t_ptr PTR_DEPTH = PW'(DEPTH);
    localparam t_ptr PTR_ONE   = PW'(1);

    localparam logic REG_QUEUE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        CMD_ENQ_ONE = 2'd0,
        CMD_ENQ_TWO = 2'd1,
        CMD_DEQ_ONE = 2'd2,
        CMD_DEQ_TWO = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    typedef struct packed {
        logic accept;
        logic load_out;
        logic load_rd;
    } t_ctrl;

endpackage

[hw/rtl/dqsa_ctrl.sv]
// controller: item handshake, result register valid, read sequencing
module dqsa_ctrl
    import dqsa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  logic  i_deq_hit,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_stall;
    logic   accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_deq_hit) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_stall        = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
        accept          = i_in_valid && !in_stall;
        o_ctrl.accept   = accept;
        o_ctrl.load_out = accept && !i_deq_hit;
        o_ctrl.load_rd  = (r_state == S_READ);
        if (o_ctrl.load_out || o_ctrl.load_rd) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = in_stall;
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/dqsa_dp.sv]
// datapath: queue pointers, slot memory and result payload register
module dqsa_dp
    import dqsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic [1:0]           i_cmd,
    input  logic signed [DW-1:0] i_write_data,
    input  logic [QSW-1:0]       i_queue_size,
    output logic                 o_deq_hit,
    output logic [1:0]           o_status,
    output logic signed [DW-1:0] o_read_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_mem_rd;

    t_ptr r_head_one, r_tail_one, r_head_two, r_tail_two;
    t_ptr n_head_one, n_tail_one, n_head_two, n_tail_two;

    t_status              r_status;
    logic signed [DW-1:0] r_read_data;

    t_cmd     cmd;
    t_ptr     size;
    t_ptr     limit;
    t_ptr     slot_one;
    t_ptr     slot_two;
    t_ptr     rd_ptr;
    logic     full_one;
    logic     full_two;
    logic     empty_one;
    logic     empty_two;
    logic     wr_en;
    t_ptr     wr_ptr;
    t_status  status;
    logic [CW-1:0] qs_ext;

    always_comb begin
        cmd    = t_cmd'(i_cmd);
        qs_ext = CW'(i_queue_size);
        if (i_queue_size == '0) begin
            size = PTR_ONE;
        end else if (qs_ext > CW'(DEPTH)) begin
            size = PTR_DEPTH;
        end else begin
            size = PW'(i_queue_size);
        end

        limit     = (r_tail_two != PTR_NONE) ? r_tail_two : size;
        slot_one  = r_tail_one + PTR_ONE;
        full_one  = (slot_one >= limit) || (slot_one < 0) || (slot_one >= PTR_DEPTH);
        slot_two  = (r_tail_two == PTR_NONE) ? size - PTR_ONE : r_tail_two - PTR_ONE;
        full_two  = (slot_two <= r_tail_one) || (slot_two < 0) || (slot_two >= PTR_DEPTH);
        empty_one = (r_head_one < 0) || (r_head_one > r_tail_one)
                    || (r_head_one >= PTR_DEPTH);
        empty_two = (r_head_two < 0) || (r_head_two < r_tail_two)
                    || (r_head_two >= PTR_DEPTH);

        n_head_one = r_head_one;
        n_tail_one = r_tail_one;
        n_head_two = r_head_two;
        n_tail_two = r_tail_two;
        wr_en      = 1'b0;
        wr_ptr     = slot_one;
        rd_ptr     = r_head_one;
        status     = ST_OK;
        o_deq_hit  = 1'b0;

        case (cmd)
            CMD_ENQ_ONE: begin
                if (full_one) begin
                    status = ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (r_tail_one == PTR_NONE) begin
                        n_head_one = '0;
                    end
                    n_tail_one = slot_one;
                end
            end
            CMD_ENQ_TWO: begin
                wr_ptr = slot_two;
                if (full_two) begin
                    status = ST_FULL;
                end else begin
                    wr_en = 1'b1;
                    if (r_tail_two == PTR_NONE) begin
                        n_head_two = slot_two;
                    end
                    n_tail_two = slot_two;
                end
            end
            CMD_DEQ_ONE: begin
                if (empty_one) begin
                    status     = ST_EMPTY;
                    n_head_one = PTR_NONE;
                    n_tail_one = PTR_NONE;
                end else begin
                    o_deq_hit = 1'b1;
                    if (r_tail_two != PTR_NONE && r_head_one + PTR_ONE == r_tail_two) begin
                        n_head_one = PTR_NONE;
                        n_tail_one = PTR_NONE;
                    end else begin
                        n_head_one = r_head_one + PTR_ONE;
                    end
                end
            end
            CMD_DEQ_TWO: begin
                rd_ptr = r_head_two;
                if (empty_two) begin
                    status     = ST_EMPTY;
                    n_head_two = PTR_NONE;
                    n_tail_two = PTR_NONE;
                end else begin
                    o_deq_hit = 1'b1;
                    if (r_head_two == r_tail_one + PTR_ONE) begin
                        n_head_two = PTR_NONE;
                        n_tail_two = PTR_NONE;
                    end else begin
                        n_head_two = r_head_two - PTR_ONE;
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_one <= PTR_NONE;
            r_tail_one <= PTR_NONE;
            r_head_two <= PTR_NONE;
            r_tail_two <= PTR_NONE;
        end else if (i_ctrl.accept) begin
            r_head_one <= n_head_one;
            r_tail_one <= n_tail_one;
            r_head_two <= n_head_two;
            r_tail_two <= n_tail_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept && wr_en) begin
            r_mem[wr_ptr[AW-1:0]] <= i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_mem_rd <= r_mem[rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_status    <= status;
            r_read_data <= '0;
        end else if (i_ctrl.load_rd) begin
            r_status    <= ST_OK;
            r_read_data <= r_mem_rd;
        end
    end

    assign o_status    = r_status;
    assign o_read_data = r_read_data;

endmodule

[hw/rtl/dual_queue_shared_array_core.sv]
// top level of the two-queue shared array: config register and wiring
// Two FIFO queues share one 64-word array: queue one fills upward from slot 0, queue two
// downward from slot queue_size-1 (queue_size clamped to 1..64). Each item is an enqueue
// or dequeue on one queue and yields one result (status, read_data). Enqueues and refused
// dequeues load the result register; a successful dequeue reads the registered memory port
// first. A new item is taken once the previous result has left or is leaving the result
// register. Write queue_size (APB-style port, address 0) only while idle; not enforced.
module dual_queue_shared_array_core
    import dqsa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_cmd,
    input  logic signed [DW-1:0] i_write_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic signed [DW-1:0] o_read_data
);

    logic [QSW-1:0] r_queue_size;
    logic           cfg_wr;
    logic           deq_hit;
    t_ctrl          ctrl;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_size <= QSW'(64);
        end else if (cfg_wr) begin
            r_queue_size <= pwdata[QSW-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_QUEUE_SIZE) begin
            prdata = {{(32 - QSW){1'b0}}, r_queue_size};
        end else begin
            prdata = '0;
        end
    end

    dqsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_deq_hit   (deq_hit),
        .o_ctrl      (ctrl)
    );

    dqsa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .i_queue_size (r_queue_size),
        .o_deq_hit    (deq_hit),
        .o_status     (o_status),
        .o_read_data  (o_read_data)
    );

endmodule

[dv/dual_queue_shared_array_core_tb.sv]
// testbench for the two-queue shared array core: predicts and checks each result
module dual_queue_shared_array_core_tb
    import dqsa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 78;

    typedef struct {
        t_status        status;
        logic [DW-1:0]  data;
    } t_outcome;

    class t_queue_pair_scoreboard;
        logic [DW-1:0]  slots [DEPTH];
        int             head_a;
        int             tail_a;
        int             head_b;
        int             tail_b;
        logic [QSW-1:0] size_reg;
        t_outcome       pending[$];
        int             errors;

        function new();
            foreach (slots[i]) slots[i] = '0;
            head_a   = -1;
            tail_a   = -1;
            head_b   = -1;
            tail_b   = -1;
            size_reg = QSW'(64);
            errors   = 0;
        endfunction

        function void set_size(logic [QSW-1:0] v);
            size_reg = v;
        endfunction

        function int span();
            if (size_reg == '0) return 1;
            if (int'(size_reg) > DEPTH) return DEPTH;
            return int'(size_reg);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function void note_item(t_cmd cmd, logic [DW-1:0] data);
            t_outcome o;
            int       sz;
            int       pos;
            int       lim;
            o.status = ST_OK;
            o.data   = '0;
            sz = span();
            case (cmd)
                CMD_ENQ_ONE: begin
                    lim = (tail_b != -1) ? tail_b : sz;
                    pos = tail_a + 1;
                    if (pos >= lim || pos < 0 || pos >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        if (tail_a == -1) head_a = 0;
                        tail_a     = pos;
                        slots[pos] = data;
                    end
                end
                CMD_ENQ_TWO: begin
                    pos = (tail_b == -1) ? sz - 1 : tail_b - 1;
                    if (pos <= tail_a || pos < 0 || pos >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        if (tail_b == -1) head_b = pos;
                        tail_b     = pos;
                        slots[pos] = data;
                    end
                end
                CMD_DEQ_ONE: begin
                    if (head_a < 0 || head_a > tail_a || head_a >= DEPTH) begin
                        o.status = ST_EMPTY;
                        head_a   = -1;
                        tail_a   = -1;
                    end else begin
                        o.data = slots[head_a];
                        if (tail_b != -1 && head_a + 1 == tail_b) begin
                            head_a = -1;
                            tail_a = -1;
                        end else begin
                            head_a = head_a + 1;
                        end
                    end
                end
                default: begin
                    if (head_b < 0 || head_b < tail_b || head_b >= DEPTH) begin
                        o.status = ST_EMPTY;
                        head_b   = -1;
                        tail_b   = -1;
                    end else begin
                        o.data = slots[head_b];
                        if (head_b == tail_a + 1) begin
                            head_b = -1;
                            tail_b = -1;
                        end else begin
                            head_b = head_b - 1;
                        end
                    end
                end
            endcase
            pending.push_back(o);
        endfunction

        function void check_result(logic [1:0] status, logic [DW-1:0] data);
            t_outcome want;
            if (pending.size() == 0) begin
                $error("result with no item pending: status %0d read_data %h", status, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, status);
                errors++;
            end
            if (data !== want.data) begin
                $error("read_data expected %h actual %h", want.data, data);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_cmd;
    logic signed [DW-1:0] i_write_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_status;
    logic signed [DW-1:0] o_read_data;

    t_queue_pair_scoreboard tracker;
    bit                     hold_req;
    bit                     steady;
    int                     idle_cycles;

    dual_queue_shared_array_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_data  (o_read_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_status, o_read_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("dual_queue_shared_array_core_tb: errors");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(t_cmd cmd, logic [DW-1:0] data);
        if (!steady && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(cmd, data);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(logic [QSW-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_QUEUE_SIZE, 2'b00};
        pwdata  <= {25'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_size(v);
    endtask

    function automatic logic [DW-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(int enq_pct);
        bit enq;
        bit two;
        enq = ($urandom_range(0, 99) < enq_pct);
        two = $urandom_range(0, 1);
        return t_cmd'({~enq, two});
    endfunction

    initial begin
        logic [QSW-1:0] size_pick;
        int             enq_pct;
        tracker      = new();
        hold_req     = 1'b0;
        steady       = 1'b0;
        idle_cycles  = 0;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_ENQ_ONE;
        i_write_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queues, extreme data, drained but not reset
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_TWO, '1);
        send_item(CMD_ENQ_ONE, 32'h7fff_ffff);
        send_item(CMD_ENQ_ONE, 32'h8000_0000);
        send_item(CMD_ENQ_TWO, 32'hffff_ffff);
        send_item(CMD_ENQ_TWO, 32'h0000_0000);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_TWO, '0);
        send_item(CMD_DEQ_ONE, '1);
        send_item(CMD_DEQ_TWO, '1);
        send_item(CMD_ENQ_ONE, 32'h5a5a_a5a5);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_TWO, '0);

        // tiny array: end of array, queue two starting low, adjacent last element
        wait_drained();
        write_size(QSW'(2));
        send_item(CMD_ENQ_ONE, 32'h1111_1111);
        send_item(CMD_ENQ_ONE, 32'h2222_2222);
        send_item(CMD_ENQ_ONE, 32'h3333_3333);
        send_item(CMD_ENQ_TWO, 32'h4444_4444);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_ENQ_TWO, 32'hcccc_cccc);
        send_item(CMD_ENQ_ONE, 32'hdddd_dddd);
        send_item(CMD_ENQ_ONE, 32'heeee_eeee);
        send_item(CMD_DEQ_ONE, '0);
        send_item(CMD_DEQ_TWO, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       size_pick = QSW'(64);
                1:       size_pick = QSW'(1);
                2:       size_pick = QSW'(0);
                3:       size_pick = QSW'(127);
                4:       size_pick = QSW'(3);
                5:       size_pick = QSW'(65);
                default: size_pick = QSW'($urandom_range(1, 64));
            endcase
            write_size(size_pick);
            enq_pct = $urandom_range(40, 85);
            if (ph == 3) begin
                enq_pct  = 85;
                hold_req = 1'b1;
            end
            if (ph == PHASES - 1) steady = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 6 && n == PHASE_ITEMS / 2) wait_drained();
                send_item(pick_cmd(enq_pct), pick_word());
            end
        end

        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("dual_queue_shared_array_core_tb: clean");
        end else begin
            $display("dual_queue_shared_array_core_tb: errors");
        end
        $finish;
    end

endmodule

[dual_queue_shared_array_core.f]
hw/rtl/dqsa_pkg.sv
hw/rtl/dqsa_ctrl.sv
hw/rtl/dqsa_dp.sv
hw/rtl/dual_queue_shared_array_core.sv
dv/dual_queue_shared_array_core_tb.sv
